[rtl/hmkd_pkg.sv]
// Shared types, constants and header table for the headered keystream decryptor.
`default_nettype none

package hmkd_pkg;

  // Result status codes
  localparam logic [1:0] ST_DATA        = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC   = 2'd1;
  localparam logic [1:0] ST_BAD_VERSION = 2'd2;
  localparam logic [1:0] ST_TRUNCATED   = 2'd3;

  // Header layout
  localparam logic [3:0] HDR_LEN     = 4'd8;
  localparam logic [3:0] MAGIC_END   = 4'd3;
  localparam logic [3:0] VERSION_END = 4'd7;

  // Twister constants
  localparam logic [9:0]  MT_LAST       = 10'd623;
  localparam logic [9:0]  MT_SHIFT      = 10'd397;
  localparam logic [9:0]  MT_WRAP       = 10'd227;
  localparam logic [31:0] MT_INIT_MULT  = 32'd1812433253;
  localparam logic [31:0] MT_MATRIX     = 32'h9908B0DF;
  localparam logic [31:0] MT_TEMPER_B   = 32'h9D2C5680;
  localparam logic [31:0] MT_TEMPER_C   = 32'hEFC60000;
  localparam logic [31:0] SEED_AT_RESET = 32'h25082011;

  // Expected header byte at each position: "LOGZ" then version 20 10 AB 01
  function automatic logic [7:0] hdr_byte(input logic [2:0] p);
    logic [7:0] b;
    case (p)
      3'd0:    b = 8'h4C;
      3'd1:    b = 8'h4F;
      3'd2:    b = 8'h47;
      3'd3:    b = 8'h5A;
      3'd4:    b = 8'h20;
      3'd5:    b = 8'h10;
      3'd6:    b = 8'hAB;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

  // Controller to datapath
  typedef struct packed {
    logic       seed_start;
    logic       seed_step;
    logic       tw_calc;
    logic       out_load;
    logic [1:0] out_status;
    logic       out_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic seed_last;
  } stat_t;

endpackage

`default_nettype wire

[rtl/hmkd_if.sv]
// Valid/ready channel interfaces for file bytes in and decrypted results out.
`default_nettype none

interface hmkd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface hmkd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       out_last;

  modport source (output valid, output out_byte, output status, output out_last, input ready);
  modport sink   (input valid, input out_byte, input status, input out_last, output ready);
endinterface

`default_nettype wire

[rtl/hmkd_ctrl.sv]
// Controller: handshakes, header check, file drop and twister sequencing.
`default_nettype none

module hmkd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_last,
  output logic               out_valid,
  input  wire logic          out_ready,
  output hmkd_pkg::cmd_t     cmd,
  input  wire hmkd_pkg::stat_t stat
);

  localparam logic [1:0] TW_IDLE = 2'd0;
  localparam logic [1:0] TW_SEED = 2'd1;
  localparam logic [1:0] TW_READ = 2'd2;
  localparam logic [1:0] TW_CALC = 2'd3;

  logic [1:0] tw_r, tw_nxt;
  logic       key_valid_r, key_valid_nxt;
  logic [3:0] hdr_pos_r, hdr_pos_nxt;
  logic       match_r, match_nxt;
  logic       drop_r, drop_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic       payload_phase;
  logic       out_free;
  logic       in_fire;
  logic       hdr_ok;
  logic       grp_match;
  logic       emit;
  logic [1:0] emit_status;
  logic       emit_last;
  logic       seed_go;
  logic       key_take;

  assign payload_phase = !drop_r && (hdr_pos_r == hmkd_pkg::HDR_LEN);
  assign out_free      = !out_valid_r || out_ready;
  assign in_ready      = out_free && (!payload_phase || key_valid_r);
  assign in_fire       = in_valid && in_ready;
  assign out_valid     = out_valid_r;

  assign hdr_ok    = (in_byte == hmkd_pkg::hdr_byte(hdr_pos_r[2:0]));
  assign grp_match = match_r && hdr_ok;

  // File-level state: header position, group match and drop
  always_comb begin
    hdr_pos_nxt = hdr_pos_r;
    match_nxt   = match_r;
    drop_nxt    = drop_r;
    emit        = 1'b0;
    emit_status = hmkd_pkg::ST_DATA;
    emit_last   = 1'b0;
    seed_go     = 1'b0;
    key_take    = 1'b0;
    if (in_fire) begin
      if (drop_r) begin
        if (in_last) begin
          hdr_pos_nxt = '0;
          match_nxt   = 1'b1;
          drop_nxt    = 1'b0;
        end
      end else if (!payload_phase) begin
        hdr_pos_nxt = hdr_pos_r + 4'd1;
        seed_go     = (hdr_pos_r == '0);
        if ((hdr_pos_r == hmkd_pkg::MAGIC_END || hdr_pos_r == hmkd_pkg::VERSION_END)
            && !grp_match) begin
          emit        = 1'b1;
          emit_status = (hdr_pos_r == hmkd_pkg::MAGIC_END) ? hmkd_pkg::ST_BAD_MAGIC
                                                           : hmkd_pkg::ST_BAD_VERSION;
          emit_last   = 1'b1;
          match_nxt   = grp_match;
          if (in_last) begin
            hdr_pos_nxt = '0;
            match_nxt   = 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
        end else begin
          match_nxt = (hdr_pos_r == hmkd_pkg::MAGIC_END) ? 1'b1 : grp_match;
          if (in_last) begin
            hdr_pos_nxt = '0;
            match_nxt   = 1'b1;
            if (hdr_pos_r != hmkd_pkg::VERSION_END) begin
              emit        = 1'b1;
              emit_status = hmkd_pkg::ST_TRUNCATED;
              emit_last   = 1'b1;
            end
          end
        end
      end else begin
        emit      = 1'b1;
        emit_last = in_last;
        key_take  = 1'b1;
        if (in_last) begin
          hdr_pos_nxt = '0;
          match_nxt   = 1'b1;
        end
      end
    end
  end

  // Twister sequencing: seed sweep, then prefetch one key at a time
  always_comb begin
    tw_nxt         = tw_r;
    key_valid_nxt  = key_valid_r;
    cmd            = '0;
    cmd.out_load   = emit;
    cmd.out_status = emit_status;
    cmd.out_last   = emit_last;
    unique case (tw_r)
      TW_IDLE: begin
      end
      TW_SEED: begin
        cmd.seed_step = 1'b1;
        if (stat.seed_last) begin
          tw_nxt = TW_READ;
        end
      end
      TW_READ: begin
        tw_nxt = TW_CALC;
      end
      TW_CALC: begin
        cmd.tw_calc   = 1'b1;
        key_valid_nxt = 1'b1;
        tw_nxt        = TW_IDLE;
      end
      default: begin
        tw_nxt = TW_IDLE;
      end
    endcase
    if (key_take) begin
      key_valid_nxt = 1'b0;
      tw_nxt        = TW_READ;
    end
    // a new file restarts the sweep whatever was in progress
    if (seed_go) begin
      cmd.seed_start = 1'b1;
      key_valid_nxt  = 1'b0;
      tw_nxt         = TW_SEED;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r        <= TW_IDLE;
      key_valid_r <= 1'b0;
      hdr_pos_r   <= '0;
      match_r     <= 1'b1;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tw_r        <= tw_nxt;
      key_valid_r <= key_valid_nxt;
      hdr_pos_r   <= hdr_pos_nxt;
      match_r     <= match_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/hmkd_dpath.sv]
// Datapath: seed register, twister word memory, seed and twist units, result register.
`default_nettype none

module hmkd_dpath (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_wr_en,
  input  wire logic [31:0]     cfg_wr_data,
  input  wire logic [7:0]      in_byte,
  input  wire hmkd_pkg::cmd_t  cmd,
  output hmkd_pkg::stat_t      stat,
  output logic [7:0]           out_byte,
  output logic [1:0]           out_status,
  output logic                 out_last
);

  logic [31:0] mem [0:623];

  logic [31:0] seed_r;
  logic [31:0] seed_copy_r, seed_copy_nxt;
  logic [31:0] cur_r, cur_nxt;
  logic [9:0]  idx_r, idx_nxt;
  logic [9:0]  pos_r, pos_nxt;
  logic [31:0] rd_next_r;
  logic [31:0] rd_far_r;
  logic [7:0]  key_r, key_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic        out_last_r, out_last_nxt;

  logic        mem_we;
  logic [9:0]  mem_waddr;
  logic [31:0] mem_wdata;
  logic [9:0]  addr_next;
  logic [9:0]  addr_far;
  logic [31:0] seed_word;
  logic [31:0] y;
  logic [31:0] tw_word;
  logic [31:0] t1, t2, t3, t4;

  assign stat.seed_last = (idx_r == hmkd_pkg::MT_LAST);

  assign addr_next = (pos_r == hmkd_pkg::MT_LAST) ? 10'd0 : pos_r + 10'd1;
  assign addr_far  = (pos_r < hmkd_pkg::MT_WRAP) ? pos_r + hmkd_pkg::MT_SHIFT
                                                 : pos_r - hmkd_pkg::MT_WRAP;

  assign seed_word = 32'(hmkd_pkg::MT_INIT_MULT * (cur_r ^ (cur_r >> 30)))
                     + {22'd0, idx_r};

  assign y       = {cur_r[31], rd_next_r[30:0]};
  assign tw_word = rd_far_r ^ (y >> 1) ^ (y[0] ? hmkd_pkg::MT_MATRIX : 32'd0);

  assign t1 = tw_word ^ (tw_word >> 11);
  assign t2 = t1 ^ ((t1 << 7) & hmkd_pkg::MT_TEMPER_B);
  assign t3 = t2 ^ ((t2 << 15) & hmkd_pkg::MT_TEMPER_C);
  assign t4 = t3 ^ (t3 >> 18);

  always_comb begin
    seed_copy_nxt = seed_copy_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    key_nxt       = key_r;
    mem_we        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = tw_word;
    if (cmd.seed_start) begin
      mem_we        = 1'b1;
      mem_waddr     = '0;
      mem_wdata     = seed_r;
      seed_copy_nxt = seed_r;
      cur_nxt       = seed_r;
      idx_nxt       = 10'd1;
      pos_nxt       = '0;
    end else if (cmd.seed_step) begin
      mem_we    = 1'b1;
      mem_waddr = idx_r;
      mem_wdata = seed_word;
      if (idx_r == hmkd_pkg::MT_LAST) begin
        // sweep done: word 0 is the first one the twist needs
        cur_nxt = seed_copy_r;
      end else begin
        cur_nxt = seed_word;
        idx_nxt = idx_r + 10'd1;
      end
    end else if (cmd.tw_calc) begin
      mem_we  = 1'b1;
      cur_nxt = rd_next_r;
      pos_nxt = addr_next;
      key_nxt = t4[31:24];
    end
  end

  always_comb begin
    out_byte_nxt   = out_byte_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    if (cmd.out_load) begin
      out_byte_nxt   = (cmd.out_status == hmkd_pkg::ST_DATA) ? (in_byte ^ key_r) : 8'd0;
      out_status_nxt = cmd.out_status;
      out_last_nxt   = cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= hmkd_pkg::SEED_AT_RESET;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      pos_r <= '0;
    end else begin
      idx_r <= idx_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seed_copy_r  <= seed_copy_nxt;
    cur_r        <= cur_nxt;
    key_r        <= key_nxt;
    out_byte_r   <= out_byte_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_next_r <= mem[addr_next];
    rd_far_r  <= mem[addr_far];
  end

  assign out_byte   = out_byte_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

[rtl/headered_mt_keystream_decrypt_core.sv]
// Top level: headered MT19937 keystream decryptor, controller plus datapath.
//
//  channel  | dir | payload                      | transfer
//  ---------+-----+------------------------------+-------------------------
//  in_ch    | in  | in_byte[7:0], in_last        | valid & ready
//  out_ch   | out | out_byte[7:0], status, last  | valid & ready
//  cfg      | in  | cfg_wr_data[31:0]            | cfg_wr_en, no wait
//
// The first byte of a file starts a seed sweep through the twister memory that
// runs beside the header; the first payload byte waits until the sweep and its
// first twist step are done. After that each payload byte uses the prefetched
// key and starts the next twist step, which the following byte waits for: two
// registered reads of the word memory, then compute and write. Reset is
// synchronous; no memory clearing pass. A stalled result blocks input.
`default_nettype none

module headered_mt_keystream_decrypt_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  hmkd_in_if.sink          in_ch,
  hmkd_out_if.source       out_ch,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data
);

  hmkd_pkg::cmd_t  cmd;
  hmkd_pkg::stat_t stat;

  hmkd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_byte   (in_ch.in_byte),
    .in_last   (in_ch.in_last),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  hmkd_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_byte     (in_ch.in_byte),
    .cmd         (cmd),
    .stat        (stat),
    .out_byte    (out_ch.out_byte),
    .out_status  (out_ch.status),
    .out_last    (out_ch.out_last)
  );

endmodule

`default_nettype wire

[rtl/hmkd_checker.sv]
// Port-level checker for the decryptor, bound to the top level.
`default_nettype none

module hmkd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic [1:0] status,
  input wire logic       out_last
);

  // hold a result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped before it was taken");

  // hold an offered input until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input transaction withdrawn before it was taken");

  // error results carry a zero byte and close the file
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != hmkd_pkg::ST_DATA |-> out_byte == 8'd0 && out_last)
    else $error("error result with non-zero byte or without last");

  // a stalled result blocks new input
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while a result is stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind headered_mt_keystream_decrypt_core hmkd_checker u_hmkd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .status    (out_ch.status),
  .out_last  (out_ch.out_last)
);

`default_nettype wire
